### hw/rtl/msl_pkg.sv
// Shared types and codes for the sample locator.
package msl_pkg;

	// Request codes, as carried on req_type.
	typedef enum logic [1:0] {
		OP_CHUNK_WR = 2'd0,
		OP_RUN_WR   = 2'd1,
		OP_SAMPLE   = 2'd2,
		OP_BEGIN    = 2'd3
	} op_t;

	// Result status codes.
	localparam logic [1:0] ST_PLACED    = 2'd0;
	localparam logic [1:0] ST_NO_TABLE  = 2'd1;
	localparam logic [1:0] ST_ZERO_RUN  = 2'd2;
	localparam logic [1:0] ST_EXHAUSTED = 2'd3;

	// Config register index, taken from paddr[2].
	localparam logic [0:0] REG_CHUNKS = 1'b0;
	localparam logic [0:0] REG_RUNS   = 1'b1;

	localparam int CHUNKS_W = 13;
	localparam int RUNS_W   = 11;
	localparam int IDX_W    = 12;

	// Classified command word passed from front to back.
	// data: chunk offset, {first chunk, samples per chunk}, or sample size.
	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] idx;
		logic [63:0]      data;
	} cmd_t;

endpackage

### hw/rtl/msl_front.sv
// Input stage: takes words, drops out-of-range table writes, queues commands.
module msl_front #(
	parameter int CHUNK_DEPTH = 4096,
	parameter int RUN_DEPTH   = 1024
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic [1:0]               req_type,
	input  logic [11:0]              table_index,
	input  logic [63:0]              chunk_offset,
	input  logic [31:0]              run_first_chunk,
	input  logic [31:0]              run_samples_per_chunk,
	input  logic [31:0]              sample_size,
	output logic                     cmd_valid,
	output msl_pkg::cmd_t            cmd,
	input  logic                     cmd_pop
);

	msl_pkg::cmd_t new_cmd;
	msl_pkg::cmd_t fifo_q [2];
	logic          keep;
	logic          enq;
	logic [1:0]    cnt_q;
	logic          wr_ptr_q;
	logic          rd_ptr_q;

	always_comb begin
		new_cmd.op   = msl_pkg::op_t'(req_type);
		new_cmd.idx  = table_index;
		new_cmd.data = '0;
		keep         = 1'b1;
		unique case (new_cmd.op)
			msl_pkg::OP_CHUNK_WR: begin
				keep         = 32'(table_index) < 32'(CHUNK_DEPTH);
				new_cmd.data = chunk_offset;
			end
			msl_pkg::OP_RUN_WR: begin
				keep         = 32'(table_index) < 32'(RUN_DEPTH);
				new_cmd.data = {run_first_chunk, run_samples_per_chunk};
			end
			msl_pkg::OP_SAMPLE: begin
				new_cmd.data = 64'(sample_size);
			end
			msl_pkg::OP_BEGIN: begin
				new_cmd.data = '0;
			end
		endcase
	end

	assign full      = (cnt_q == 2'd2);
	assign enq       = push && !full && keep;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (enq) begin
			fifo_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			cnt_q <= cnt_q + 2'(enq) - 2'(cmd_pop);
			if (enq) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
		end
	end

endmodule

### hw/rtl/msl_back.sv
// Walk engine: table memories, chunk/run walk sequencer and result register.
module msl_back #(
	parameter int CHUNK_DEPTH = 4096,
	parameter int RUN_DEPTH   = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [12:0]           chunks_in_use,
	input  logic [10:0]           runs_in_use,
	input  logic                  cmd_valid,
	input  msl_pkg::cmd_t         cmd,
	output logic                  cmd_pop,
	input  logic                  pop,
	output logic                  res_valid,
	output logic [63:0]           sample_offset,
	output logic [31:0]           sample_bytes,
	output logic [1:0]            status
);

	localparam int CW  = (CHUNK_DEPTH > 1) ? $clog2(CHUNK_DEPTH) : 1;
	localparam int RW  = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
	localparam int CKW = (CW + 1 > 13) ? CW + 1 : 13;
	localparam int RKW = (RW + 1 > 11) ? RW + 1 : 11;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHK,
		S_ADV,
		S_ADVCHK,
		S_OPEN
	} state_t;

	typedef enum logic [1:0] {
		W_NOT_STARTED,
		W_IN_CHUNK,
		W_STOPPED,
		W_EXHAUSTED
	} walk_t;

	state_t           state_q;
	walk_t            walk_q;
	logic [CW-1:0]    cur_chunk_q;
	logic [RW-1:0]    cur_run_q;
	logic [31:0]      placed_q;
	logic [63:0]      run_off_q;
	logic [31:0]      size_q;
	logic             res_valid_q;
	logic [63:0]      res_off_q;
	logic [31:0]      res_bytes_q;
	logic [1:0]       res_status_q;

	logic [63:0]      chunk_mem [CHUNK_DEPTH];
	logic [63:0]      run_mem [RUN_DEPTH];
	logic [63:0]      chunk_rd_q;
	logic [63:0]      run_rd_q;

	logic [CKW-1:0]   live_chunks;
	logic [RKW-1:0]   live_runs;
	logic [CKW-1:0]   next_chunk;
	logic             tables_empty;
	logic             run_more;
	logic             run_first_ok;
	logic             res_free;
	logic             chunk_we;
	logic             run_we;
	logic [CW-1:0]    chunk_addr;
	logic [RW-1:0]    run_addr;
	logic [RW-1:0]    run_raddr;

	// Counts saturate at the store depth.
	assign live_chunks = (CKW'(chunks_in_use) > CKW'(CHUNK_DEPTH)) ?
		CKW'(CHUNK_DEPTH) : CKW'(chunks_in_use);
	assign live_runs   = (RKW'(runs_in_use) > RKW'(RUN_DEPTH)) ?
		RKW'(RUN_DEPTH) : RKW'(runs_in_use);

	assign tables_empty = (chunks_in_use == '0) || (runs_in_use == '0);
	assign next_chunk   = (walk_q == W_NOT_STARTED) ? '0 : CKW'(cur_chunk_q) + CKW'(1);
	assign run_more     = (RKW'(cur_run_q) + RKW'(1)) < live_runs;
	// run_rd_q holds the next run's entry; first chunk is one-based
	assign run_first_ok = {1'b0, run_rd_q[63:32]} <= (33'(cur_chunk_q) + 33'd1);

	assign res_free = !res_valid_q || pop;
	assign cmd_pop  = (state_q == S_IDLE) && cmd_valid &&
		((cmd.op != msl_pkg::OP_SAMPLE) || res_free);
	assign chunk_we = cmd_pop && (cmd.op == msl_pkg::OP_CHUNK_WR);
	assign run_we   = cmd_pop && (cmd.op == msl_pkg::OP_RUN_WR);

	always_comb begin
		run_raddr = cur_run_q;
		if (state_q == S_ADV && run_more) begin
			run_raddr = cur_run_q + RW'(1);
		end
	end

	assign run_addr   = run_we ? RW'({{RW{1'b0}}, cmd.idx}) : run_raddr;
	assign chunk_addr = chunk_we ? CW'({{CW{1'b0}}, cmd.idx}) : cur_chunk_q;

	always_ff @(posedge clk) begin
		if (chunk_we) begin
			chunk_mem[chunk_addr] <= cmd.data;
		end
		chunk_rd_q <= chunk_mem[chunk_addr];
	end

	always_ff @(posedge clk) begin
		if (run_we) begin
			run_mem[run_addr] <= cmd.data;
		end
		run_rd_q <= run_mem[run_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			walk_q       <= W_NOT_STARTED;
			cur_chunk_q  <= '0;
			cur_run_q    <= '0;
			placed_q     <= '0;
			run_off_q    <= '0;
			size_q       <= '0;
			res_valid_q  <= 1'b0;
			res_off_q    <= '0;
			res_bytes_q  <= '0;
			res_status_q <= msl_pkg::ST_PLACED;
		end else begin
			if (pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_pop) begin
						unique case (cmd.op)
							msl_pkg::OP_CHUNK_WR, msl_pkg::OP_RUN_WR: begin
							end
							msl_pkg::OP_BEGIN: begin
								walk_q      <= W_NOT_STARTED;
								cur_chunk_q <= '0;
								cur_run_q   <= '0;
								placed_q    <= '0;
								run_off_q   <= '0;
							end
							msl_pkg::OP_SAMPLE: begin
								size_q      <= cmd.data[31:0];
								res_bytes_q <= cmd.data[31:0];
								res_off_q   <= '0;
								if (tables_empty) begin
									res_valid_q  <= 1'b1;
									res_status_q <= msl_pkg::ST_NO_TABLE;
								end else if (walk_q == W_STOPPED) begin
									res_valid_q  <= 1'b1;
									res_status_q <= msl_pkg::ST_ZERO_RUN;
								end else if (walk_q == W_EXHAUSTED) begin
									res_valid_q  <= 1'b1;
									res_status_q <= msl_pkg::ST_EXHAUSTED;
								end else begin
									state_q <= S_CHK;
								end
							end
						endcase
					end
				end
				S_CHK: begin
					// run_rd_q: entry of the current run
					if (walk_q == W_NOT_STARTED || placed_q >= run_rd_q[31:0]) begin
						if (next_chunk >= live_chunks) begin
							walk_q       <= W_EXHAUSTED;
							res_valid_q  <= 1'b1;
							res_off_q    <= '0;
							res_status_q <= msl_pkg::ST_EXHAUSTED;
							state_q      <= S_IDLE;
						end else begin
							cur_chunk_q <= next_chunk[CW-1:0];
							state_q     <= S_ADV;
						end
					end else begin
						res_valid_q  <= 1'b1;
						res_off_q    <= run_off_q;
						res_status_q <= msl_pkg::ST_PLACED;
						run_off_q    <= run_off_q + 64'(size_q);
						placed_q     <= placed_q + 32'd1;
						state_q      <= S_IDLE;
					end
				end
				S_ADV: begin
					state_q <= run_more ? S_ADVCHK : S_OPEN;
				end
				S_ADVCHK: begin
					if (run_first_ok) begin
						cur_run_q <= cur_run_q + RW'(1);
						state_q   <= S_ADV;
					end else begin
						state_q <= S_OPEN;
					end
				end
				S_OPEN: begin
					res_valid_q <= 1'b1;
					if (run_rd_q[31:0] == 32'd0) begin
						walk_q       <= W_STOPPED;
						res_off_q    <= '0;
						res_status_q <= msl_pkg::ST_ZERO_RUN;
					end else begin
						walk_q       <= W_IN_CHUNK;
						res_off_q    <= chunk_rd_q;
						res_status_q <= msl_pkg::ST_PLACED;
						run_off_q    <= chunk_rd_q + 64'(size_q);
						placed_q     <= 32'd1;
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res_valid     = res_valid_q;
	assign sample_offset = res_off_q;
	assign sample_bytes  = res_bytes_q;
	assign status        = res_status_q;

endmodule

### hw/rtl/mp4_sample_locator.sv
// Sample locator top level: config registers, front queue and walk engine.
// Flow: table writes and begin words retire when the walk engine takes them. A sample
//   answered from the walk state alone (empty table, stopped, exhausted) shows its
//   result from the idle state; one inside an open chunk or off the chunk table passes
//   the check state; one that opens a chunk passes check, advance and open, plus
//   advance-check if a later run entry exists, and advance and advance-check per entry
//   stepped over. Samples in a chunk go one at a time (run-table read, then the add),
//   only while the result register is free; a 2-word queue decouples input from the walk.
// Reset: walk not started, counts zero, queue and result empty; tables hold no value
//   until written.
module mp4_sample_locator #(
	parameter int CHUNK_DEPTH = 4096,
	parameter int RUN_DEPTH   = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	// input word channel
	input  logic        push,
	output logic        full,
	input  logic [1:0]  req_type,
	input  logic [11:0] table_index,
	input  logic [63:0] chunk_offset,
	input  logic [31:0] run_first_chunk,
	input  logic [31:0] run_samples_per_chunk,
	input  logic [31:0] sample_size,
	// result word channel
	output logic        empty,
	input  logic        pop,
	output logic [63:0] sample_offset,
	output logic [31:0] sample_bytes,
	output logic [1:0]  status,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [msl_pkg::CHUNKS_W-1:0] chunks_q;
	logic [msl_pkg::RUNS_W-1:0]   runs_q;
	logic                         cfg_wr;
	logic                         cmd_valid;
	logic                         cmd_pop;
	msl_pkg::cmd_t                cmd;
	logic                         res_valid;

	// Config port: pready tied high, register index on paddr[2].
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunks_q <= '0;
			runs_q   <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[2:2])
				msl_pkg::REG_CHUNKS: chunks_q <= pwdata[msl_pkg::CHUNKS_W-1:0];
				msl_pkg::REG_RUNS:   runs_q   <= pwdata[msl_pkg::RUNS_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2:2])
			msl_pkg::REG_CHUNKS: prdata = 32'(chunks_q);
			msl_pkg::REG_RUNS:   prdata = 32'(runs_q);
		endcase
	end

	// Front: classify, drop out-of-range writes, queue.
	msl_front #(
		.CHUNK_DEPTH(CHUNK_DEPTH),
		.RUN_DEPTH  (RUN_DEPTH)
	) u_front (
		.clk                  (clk),
		.arst_n               (arst_n),
		.push                 (push),
		.full                 (full),
		.req_type             (req_type),
		.table_index          (table_index),
		.chunk_offset         (chunk_offset),
		.run_first_chunk      (run_first_chunk),
		.run_samples_per_chunk(run_samples_per_chunk),
		.sample_size          (sample_size),
		.cmd_valid            (cmd_valid),
		.cmd                  (cmd),
		.cmd_pop              (cmd_pop)
	);

	// Back: table memories and the chunk/run walk; one result register.
	msl_back #(
		.CHUNK_DEPTH(CHUNK_DEPTH),
		.RUN_DEPTH  (RUN_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.chunks_in_use(chunks_q),
		.runs_in_use  (runs_q),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop),
		.pop          (pop),
		.res_valid    (res_valid),
		.sample_offset(sample_offset),
		.sample_bytes (sample_bytes),
		.status       (status)
	);

	assign empty = !res_valid;

	// An unplaced sample always reports a zero offset.
	a_unplaced_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != msl_pkg::ST_PLACED) |-> (sample_offset == 64'd0))
		else $error("unplaced sample with nonzero offset");

	// Empty-table status only when a count register is zero.
	a_no_table: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == msl_pkg::ST_NO_TABLE) |-> (chunks_q == '0 || runs_q == '0))
		else $error("empty-table status with both tables present");

	// A placed sample needs both tables.
	a_placed_tables: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == msl_pkg::ST_PLACED) |-> (chunks_q != '0 && runs_q != '0))
		else $error("sample placed with an empty table");

endmodule

### bench/mp4_sample_locator_tb.sv
// Self-checking bench for mp4_sample_locator: table loads, track walks, APB setup.

// Walk phases of the sample locator, mirrored by the bench.
typedef enum logic [1:0] {
	PH_FRESH,
	PH_IN_CHUNK,
	PH_STOPPED,
	PH_EXHAUSTED
} walk_phase_t;

// One input word as it crosses the push side.
typedef struct {
	msl_pkg::op_t              op;
	logic [msl_pkg::IDX_W-1:0] idx;
	logic [63:0]               base;
	logic [31:0]               first;
	logic [31:0]               per_chunk;
	logic [31:0]               size;
} in_word_t;

// One located sample as it leaves the pop side.
typedef struct {
	logic [63:0] offs;
	logic [31:0] bytes;
	logic [1:0]  st;
} loc_t;

// Table copy, walk state and the queue of sample locations still due.
class sample_walk #(int CHUNKS = 4096, int RUNS = 1024);
	bit [63:0]                  chunk_base [CHUNKS];
	bit                         chunk_seen [CHUNKS];
	bit [31:0]                  run_first [RUNS];
	bit [31:0]                  run_per_chunk [RUNS];
	bit                         run_seen [RUNS];
	bit [msl_pkg::CHUNKS_W-1:0] chunks_reg;
	bit [msl_pkg::RUNS_W-1:0]   runs_reg;
	bit [12:0]                  cur_chunk;
	bit [9:0]                   cur_run;
	bit [31:0]                  placed;
	bit [63:0]                  fill_offs;
	walk_phase_t                walk;
	bit                         blind_read;
	loc_t                       due_locs[$];
	int                         errors;

	function new();
		restart();
		errors = 0;
	endfunction

	function void restart();
		cur_chunk = '0;
		cur_run = '0;
		placed = '0;
		fill_offs = '0;
		walk = PH_FRESH;
	endfunction

	function void set_reg(logic [0:0] which, logic [31:0] v);
		if (which == msl_pkg::REG_CHUNKS)
			chunks_reg = v[msl_pkg::CHUNKS_W-1:0];
		else
			runs_reg = v[msl_pkg::RUNS_W-1:0];
	endfunction

	function int unsigned live_chunks();
		return (chunks_reg > CHUNKS) ? CHUNKS : chunks_reg;
	endfunction

	function int unsigned live_runs();
		return (runs_reg > RUNS) ? RUNS : runs_reg;
	endfunction

	// Move to the next chunk; blind_read flags any table entry never loaded.
	function logic [1:0] open_chunk();
		int unsigned nxt;
		int unsigned runs;
		bit stepping;
		nxt = (walk == PH_FRESH) ? 0 : cur_chunk + 1;
		runs = live_runs();
		if (nxt >= live_chunks()) begin
			walk = PH_EXHAUSTED;
			return msl_pkg::ST_EXHAUSTED;
		end
		cur_chunk = nxt[12:0];
		stepping = 1'b1;
		while (stepping && cur_run + 1 < runs) begin
			if (!run_seen[cur_run + 1])
				blind_read = 1'b1;
			if (run_first[cur_run + 1] <= nxt + 1)
				cur_run++;
			else
				stepping = 1'b0;
		end
		if (!run_seen[cur_run])
			blind_read = 1'b1;
		if (run_per_chunk[cur_run] == 0) begin
			walk = PH_STOPPED;
			return msl_pkg::ST_ZERO_RUN;
		end
		if (!chunk_seen[nxt])
			blind_read = 1'b1;
		fill_offs = chunk_base[nxt];
		placed = '0;
		walk = PH_IN_CHUNK;
		return msl_pkg::ST_PLACED;
	endfunction

	function loc_t locate(bit [31:0] size);
		loc_t r;
		r.offs = '0;
		r.bytes = size;
		r.st = msl_pkg::ST_PLACED;
		if (live_chunks() == 0 || live_runs() == 0)
			r.st = msl_pkg::ST_NO_TABLE;
		else if (walk == PH_STOPPED)
			r.st = msl_pkg::ST_ZERO_RUN;
		else if (walk == PH_EXHAUSTED)
			r.st = msl_pkg::ST_EXHAUSTED;
		else begin
			if (walk == PH_FRESH)
				r.st = open_chunk();
			else begin
				if (!run_seen[cur_run])
					blind_read = 1'b1;
				if (placed >= run_per_chunk[cur_run])
					r.st = open_chunk();
			end
			if (r.st == msl_pkg::ST_PLACED) begin
				r.offs = fill_offs;
				fill_offs += size;
				placed++;
			end
		end
		return r;
	endfunction

	// Dry run of the next sample: true when it reads only loaded entries.
	function bit sample_is_safe();
		bit [12:0]   c;
		bit [9:0]    rn;
		bit [31:0]   p;
		bit [63:0]   o;
		walk_phase_t wk;
		c = cur_chunk;
		rn = cur_run;
		p = placed;
		o = fill_offs;
		wk = walk;
		blind_read = 1'b0;
		void'(locate('0));
		cur_chunk = c;
		cur_run = rn;
		placed = p;
		fill_offs = o;
		walk = wk;
		return !blind_read;
	endfunction

	function void note_word(in_word_t w);
		case (w.op)
			msl_pkg::OP_CHUNK_WR: begin
				if (int'(w.idx) < CHUNKS) begin
					chunk_base[w.idx] = w.base;
					chunk_seen[w.idx] = 1'b1;
				end
			end
			msl_pkg::OP_RUN_WR: begin
				if (int'(w.idx) < RUNS) begin
					run_first[w.idx] = w.first;
					run_per_chunk[w.idx] = w.per_chunk;
					run_seen[w.idx] = 1'b1;
				end
			end
			msl_pkg::OP_SAMPLE: due_locs = {due_locs, locate(w.size)};
			msl_pkg::OP_BEGIN: restart();
		endcase
	endfunction

	task report(string msg);
		$display("%0t ERROR %s", $time, msg);
		errors++;
	endtask

	task check_result(loc_t got);
		loc_t want;
		if (due_locs.size() == 0) begin
			report($sformatf("result with none due: offset %h bytes %h status %0d",
				got.offs, got.bytes, got.st));
			return;
		end
		want = due_locs.pop_front();
		if (got.offs !== want.offs)
			report($sformatf("sample_offset %h, want %h", got.offs, want.offs));
		if (got.bytes !== want.bytes)
			report($sformatf("sample_bytes %h, want %h", got.bytes, want.bytes));
		if (got.st !== want.st)
			report($sformatf("status %0d, want %0d", got.st, want.st));
	endtask
endclass

module mp4_sample_locator_tb;
	localparam int CHUNK_DEPTH = 4096;
	localparam int RUN_DEPTH   = 1024;
	// random part stops once this many words have gone in
	localparam int WORD_TARGET = 1090;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [1:0]  req_type;
	logic [11:0] table_index;
	logic [63:0] chunk_offset;
	logic [31:0] run_first_chunk;
	logic [31:0] run_samples_per_chunk;
	logic [31:0] sample_size;
	logic        empty;
	logic        pop;
	logic [63:0] sample_offset;
	logic [31:0] sample_bytes;
	logic [1:0]  status;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	sample_walk #(CHUNK_DEPTH, RUN_DEPTH) sb;
	bit busy_mode;   // both sides run flat out while set
	int word_count;

	mp4_sample_locator #(
		.CHUNK_DEPTH(CHUNK_DEPTH),
		.RUN_DEPTH  (RUN_DEPTH)
	) dut (
		.clk                  (clk),
		.arst_n               (arst_n),
		.push                 (push),
		.full                 (full),
		.req_type             (req_type),
		.table_index          (table_index),
		.chunk_offset         (chunk_offset),
		.run_first_chunk      (run_first_chunk),
		.run_samples_per_chunk(run_samples_per_chunk),
		.sample_size          (sample_size),
		.empty                (empty),
		.pop                  (pop),
		.sample_offset        (sample_offset),
		.sample_bytes         (sample_bytes),
		.status               (status),
		.psel                 (psel),
		.penable              (penable),
		.pwrite               (pwrite),
		.paddr                (paddr),
		.pwdata               (pwdata),
		.prdata               (prdata),
		.pready               (pready)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Gap lengths: mostly none or short, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// All fields random; callers overwrite what the op actually uses.
	function automatic in_word_t junk_word(msl_pkg::op_t op);
		in_word_t w;
		w.op = op;
		w.idx = (msl_pkg::IDX_W)'($urandom_range(0, 4095));
		w.base = {$urandom, $urandom};
		w.first = $urandom;
		w.per_chunk = $urandom;
		w.size = $urandom;
		return w;
	endfunction

	function automatic logic [63:0] pick_base();
		case ($urandom_range(0, 3))
			0: return {$urandom, $urandom};
			1: return 64'hFFFF_FFFF_FFFF_F000 | 64'($urandom_range(0, 4095)); // near wrap
			default: return {32'h0, $urandom};
		endcase
	endfunction

	function automatic logic [31:0] pick_per_chunk();
		int r;
		r = $urandom_range(0, 19);
		if (r < 2)
			return 32'd0;          // stops the walk
		if (r == 2)
			return 32'hFFFF_FFFF;  // chunk never closes
		return $urandom_range(1, 4);
	endfunction

	function automatic logic [31:0] pick_size();
		return ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2000);
	endfunction

	// Watch both handshakes at the rising edge; inputs only move on the falling one.
	always @(posedge clk) begin : watch
		in_word_t w;
		loc_t got;
		if (arst_n === 1'b1) begin
			if (push && !full) begin
				w.op = msl_pkg::op_t'(req_type);
				w.idx = table_index;
				w.base = chunk_offset;
				w.first = run_first_chunk;
				w.per_chunk = run_samples_per_chunk;
				w.size = sample_size;
				sb.note_word(w);
			end
			if (pop && !empty) begin
				got.offs = sample_offset;
				got.bytes = sample_bytes;
				got.st = status;
				sb.check_result(got);
			end
		end
	end

	// Drive one word and hold it until taken; may idle afterwards.
	task automatic send_word(in_word_t w);
		int n;
		push = 1'b1;
		req_type = w.op;
		table_index = w.idx;
		chunk_offset = w.base;
		run_first_chunk = w.first;
		run_samples_per_chunk = w.per_chunk;
		sample_size = w.size;
		do @(posedge clk); while (full);
		// run writes past the table are dropped by the block, so not counted
		if (!(w.op == msl_pkg::OP_RUN_WR && int'(w.idx) >= RUN_DEPTH))
			word_count++;
		@(negedge clk);
		n = busy_mode ? 0 : gap_len();
		if (n > 0) begin
			push = 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	// A sample that would read a never-loaded entry is swapped for a begin word.
	task automatic send_sample(logic [31:0] size);
		in_word_t w;
		if (sb.sample_is_safe()) begin
			w = junk_word(msl_pkg::OP_SAMPLE);
			w.size = size;
		end else
			w = junk_word(msl_pkg::OP_BEGIN);
		send_word(w);
	endtask

	task automatic send_table(msl_pkg::op_t op, int idx, logic [63:0] base,
			logic [31:0] first, logic [31:0] per_chunk);
		in_word_t w;
		w = junk_word(op);
		w.idx = (msl_pkg::IDX_W)'(idx);
		w.base = base;
		w.first = first;
		w.per_chunk = per_chunk;
		send_word(w);
	endtask

	task automatic wait_results();
		push = 1'b0;
		while (sb.due_locs.size() != 0) @(negedge clk);
	endtask

	// Quiet the block before touching registers: table and begin words
	// leave no result, so give them time to retire.
	task automatic settle();
		wait_results();
		repeat (32) @(negedge clk);
	endtask

	// APB write with random upper bits, then read back the masked value.
	task automatic program_reg(logic [0:0] which, int unsigned count);
		logic [31:0] v;
		logic [31:0] want;
		v = $urandom;
		if (which == msl_pkg::REG_CHUNKS)
			v[msl_pkg::CHUNKS_W-1:0] = count[msl_pkg::CHUNKS_W-1:0];
		else
			v[msl_pkg::RUNS_W-1:0] = count[msl_pkg::RUNS_W-1:0];
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {which, 2'b00};
		pwdata = v;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(which, v);
		@(negedge clk);
		pwrite = 1'b0;
		penable = 1'b0;
		want = (which == msl_pkg::REG_CHUNKS) ? 32'(sb.chunks_reg) : 32'(sb.runs_reg);
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want)
			sb.report($sformatf("register %0d reads %h, want %h", which, prdata, want));
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	// Well-formed track: load chunks and runs, begin, then walk samples.
	task automatic play_track(int nc, int nr);
		logic [31:0] first;
		int i;
		int n;
		for (i = 0; i < nc; i++)
			send_table(msl_pkg::OP_CHUNK_WR, i, pick_base(), $urandom, $urandom);
		first = ($urandom_range(0, 4) == 0) ? 32'($urandom_range(0, 2)) : 32'd1;
		for (i = 0; i < nr; i++) begin
			send_table(msl_pkg::OP_RUN_WR, i, {$urandom, $urandom}, first, pick_per_chunk());
			first += $urandom_range(1, 3);
		end
		// far-off run after the last one keeps the run step from reading further
		if ($urandom_range(0, 1))
			send_table(msl_pkg::OP_RUN_WR, nr, {$urandom, $urandom},
				$urandom | 32'h8000_0000, pick_per_chunk());
		send_word(junk_word(msl_pkg::OP_BEGIN));
		n = $urandom_range(nc, 3 * nc + 4);
		repeat (n) send_sample(pick_size());
	endtask

	task automatic send_noise(int n);
		in_word_t w;
		repeat (n) begin
			w = junk_word(msl_pkg::op_t'($urandom_range(0, 3)));
			if (w.op == msl_pkg::OP_SAMPLE)
				send_sample(w.size);
			else
				send_word(w);
		end
	endtask

	// Receiver: pops with random stalls, or every cycle in a busy stretch.
	initial begin : pop_drive
		int stall;
		stall = 0;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (busy_mode)
				pop = 1'b1;
			else if (stall > 0) begin
				pop = 1'b0;
				stall--;
			end else begin
				pop = 1'b1;
				if ($urandom_range(0, 2) == 0)
					stall = gap_len();
			end
		end
	end

	initial begin : stimulus
		int phase;
		int ext_n;
		int k;
		int stop_at;
		int tr_c;
		int tr_r;
		int spin;
		int unsigned n_ch;
		int unsigned n_run;
		sb = new();
		busy_mode = 1'b0;
		word_count = 0;
		arst_n = 1'b0;
		push = 1'b0;
		req_type = msl_pkg::OP_CHUNK_WR;
		table_index = '0;
		chunk_offset = '0;
		run_first_chunk = '0;
		run_samples_per_chunk = '0;
		sample_size = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: empty tables, extreme indexes, out-of-range run write.
		send_sample(32'hFFFF_FFFF);
		send_table(msl_pkg::OP_CHUNK_WR, 0, 64'hFFFF_FFFF_FFFF_FFF0, 0, 0);
		send_table(msl_pkg::OP_CHUNK_WR, 1, 64'h0, 0, 0);
		send_table(msl_pkg::OP_CHUNK_WR, 2, 64'h8000_0000_0000_0000, 0, 0);
		send_table(msl_pkg::OP_CHUNK_WR, 4095, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0);
		send_table(msl_pkg::OP_RUN_WR, 0, 64'h0, 32'd1, 32'd2);
		send_table(msl_pkg::OP_RUN_WR, 1, 64'h0, 32'd3, 32'd0);
		send_table(msl_pkg::OP_RUN_WR, 1023, 64'h0, 32'd0, 32'hFFFF_FFFF);
		send_table(msl_pkg::OP_RUN_WR, 4095, 64'h0, 32'hFFFF_FFFF, 32'd0);
		send_word(junk_word(msl_pkg::OP_BEGIN));

		// Two chunks: offset wraps inside chunk 0, then the table runs out.
		settle();
		program_reg(msl_pkg::REG_CHUNKS, 2);
		program_reg(msl_pkg::REG_RUNS, 2);
		send_sample(32'h10);
		send_sample(32'h20);
		send_sample(32'h0);
		send_sample(32'h5);
		send_sample(32'h1);
		send_sample(32'h1);
		send_word(junk_word(msl_pkg::OP_BEGIN));

		// Saturated chunk count; chunk 2 falls in a run with zero samples.
		settle();
		program_reg(msl_pkg::REG_CHUNKS, 8191);
		send_sample(32'h0);
		send_sample(32'h0);
		send_sample(32'h7);
		send_sample(32'h0);
		send_sample(32'h3);
		send_sample(32'h3);
		send_word(junk_word(msl_pkg::OP_BEGIN));

		// Random phases. Every third phase takes register extremes, the
		// others match the track size or pick counts at random.
		phase = 0;
		ext_n = 0;
		while (word_count < WORD_TARGET) begin
			settle();
			tr_c = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
			tr_r = $urandom_range(1, 6);
			case (phase % 3)
				0: begin
					n_ch = ($urandom_range(0, 2) == 0) ? $urandom_range(1, tr_c) : tr_c;
					n_run = tr_r + $urandom_range(0, 1);
				end
				1: begin
					case (ext_n % 4)
						0: n_ch = 0;
						1: n_ch = 1;
						2: n_ch = CHUNK_DEPTH;
						default: n_ch = 8191;
					endcase
					case ((ext_n + 2) % 4)
						0: n_run = 0;
						1: n_run = 1;
						2: n_run = RUN_DEPTH;
						default: n_run = 2047;
					endcase
					ext_n++;
				end
				default: begin
					n_ch = $urandom_range(0, 1) ? $urandom_range(0, 8191) : $urandom_range(0, tr_c);
					n_run = $urandom_range(0, 1) ? $urandom_range(0, 2047)
						: $urandom_range(0, tr_r + 1);
				end
			endcase
			program_reg(msl_pkg::REG_CHUNKS, n_ch);
			program_reg(msl_pkg::REG_RUNS, n_run);
			busy_mode = ($urandom_range(0, 3) == 0);
			stop_at = word_count + $urandom_range(40, 120);
			while (word_count < stop_at) begin
				k = $urandom_range(0, 9);
				if (k < 6)
					play_track(tr_c, tr_r);
				else if (k < 8)
					send_noise($urandom_range(1, 12));
				else if (k == 8) begin
					// broken track: stray chunk loads and samples, no begin
					repeat ($urandom_range(0, 2))
						send_table(msl_pkg::OP_CHUNK_WR, $urandom_range(0, tr_c - 1),
							pick_base(), $urandom, $urandom);
					repeat ($urandom_range(1, 8)) send_sample(pick_size());
				end else
					wait_results();
			end
			phase++;
		end

		// Drain, then a tail for any late or stray result.
		busy_mode = 1'b0;
		push = 1'b0;
		spin = 0;
		while (sb.due_locs.size() != 0 && spin < 50000) begin
			@(negedge clk);
			spin++;
		end
		repeat (40) @(negedge clk);
		if (sb.due_locs.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.due_locs.size()));
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Hang guard, far beyond the slowest legal run.
	initial begin : watchdog
		#8000000;
		$display("*** FAILED ***");
		$finish;
	end
endmodule
